// ===== rtl/core/lnss_pkg.sv =====
package lnss_pkg;

  // Default sizes of the two stores
  localparam int DEF_MAX_LAYERS = 16;
  localparam int DEF_LIST_DEPTH = 32;

  // Fixed field widths
  localparam int ID_W     = 31;
  localparam int OP_W     = 3;
  localparam int LAYER_W  = 4;
  localparam int RIDX_W   = 5;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 5;
  localparam int COUNT_W  = 6;

  // Operation codes
  localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
  localparam logic [OP_W-1:0] OP_HAS    = 3'd2;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
  localparam logic [OP_W-1:0] OP_READ   = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OOB      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_PAST_END = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [LAYER_W-1:0] layer_select;
    logic [ID_W-1:0]    neighbor_id;
    logic [RIDX_W-1:0]  read_index;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                succeeded;
    logic [POS_W-1:0]    position;
    logic [ID_W-1:0]     entry_value;
    logic [COUNT_W-1:0]  list_count;
  } rsp_t;

endpackage

// ===== rtl/core/lnss_id_ram.sv =====
module lnss_id_ram #(
  parameter int DEPTH = lnss_pkg::DEF_MAX_LAYERS * lnss_pkg::DEF_LIST_DEPTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AW-1:0]             waddr_i,
  input  logic [lnss_pkg::ID_W-1:0] wdata_i,
  input  logic                      re_i,
  input  logic [AW-1:0]             raddr_i,
  output logic [lnss_pkg::ID_W-1:0] rdata_o
);

  logic [lnss_pkg::ID_W-1:0] mem [DEPTH];
  logic [lnss_pkg::ID_W-1:0] rdata_q;

  // Write one id; the read of one id is registered
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/lnss_cnt_store.sv =====
module lnss_cnt_store #(
  parameter int LAYERS = lnss_pkg::DEF_MAX_LAYERS,
  parameter int LW     = 4,
  parameter int CW     = 6
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          we_i,
  input  logic [LW-1:0] waddr_i,
  input  logic [CW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [LW-1:0] raddr_i,
  output logic [CW-1:0] rdata_o
);

  logic [CW-1:0]     mem [LAYERS];
  logic [LAYERS-1:0] valid_q;
  logic [CW-1:0]     rdata_q;
  logic              rvalid_q;

  // Count memory, read data registered
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  // Track which layers hold a written count; others read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvalid_q <= valid_q[raddr_i];
      end
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

// ===== rtl/core/layered_neighbor_set_store_unit.sv =====
// Layered neighbor set store: one ordered, duplicate-free list of neighbor
// ids for each layer of a graph node.
// Request channel: present req_i with start_i high; the request transfers
// at a rising edge where start_i is high and busy_o is low. busy_o stays
// high while the request is worked on.
// Result channel: done_o is high for exactly one cycle with rsp_o; the
// receiver takes it in that cycle and cannot stall. Every request gives
// exactly one result. busy_o is low in the done_o cycle, so the next
// request may transfer there.
// Steps: a request first reads its layer's entry count; clear, other ops and
// layers out of bounds then report. Read then fetches the entry and reports;
// add, has and remove search the list one entry at a time from index 0, and
// remove then shifts the later entries down one place before it reports.
// The id memory serves one read and one write a cycle: search reads one entry
// a cycle, and removal then moves one entry down a cycle.
// Configuration: cfg_we_i writes cfg_wdata_i into top_layer; write it only
// while no request is in flight.
// Reset: all lists empty, top_layer zero; no clearing pass is needed.
module layered_neighbor_set_store_unit #(
  parameter int MAX_LAYERS = lnss_pkg::DEF_MAX_LAYERS,
  parameter int LIST_DEPTH = lnss_pkg::DEF_LIST_DEPTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  lnss_pkg::req_t               req_i,
  output logic                         done_o,
  output lnss_pkg::rsp_t               rsp_o,
  input  logic                         cfg_we_i,
  input  logic [lnss_pkg::LAYER_W-1:0] cfg_wdata_i
);

  localparam int LW    = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
  localparam int IW    = $clog2(LIST_DEPTH);
  localparam int CW    = $clog2(LIST_DEPTH + 1);
  localparam int CMPW  = (CW > lnss_pkg::RIDX_W) ? CW : lnss_pkg::RIDX_W;
  localparam int DEPTH = MAX_LAYERS * LIST_DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] ROW_A  = AW'(LIST_DEPTH);
  localparam logic [CW-1:0] FULL_C = CW'(LIST_DEPTH);
  localparam logic [CW-1:0] ONE_C  = CW'(1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CNT,
    S_SCAN,
    S_SHIFT,
    S_RDWAIT
  } state_e;

  state_e                       state_q, state_d;
  lnss_pkg::req_t               req_q, req_d;
  logic [LW-1:0]                layer_q, layer_d;
  logic                         oob_q, oob_d;
  logic [CW-1:0]                cnt_q, cnt_d;
  logic [CW-1:0]                idx_q, idx_d;
  logic                         done_q, done_d;
  lnss_pkg::rsp_t               rsp_q, rsp_d;
  logic [lnss_pkg::LAYER_W-1:0] top_q;

  // Memory ports
  logic                      cnt_re, cnt_we;
  logic [LW-1:0]             cnt_raddr;
  logic [CW-1:0]             cnt_wdata, cnt_rdata;
  logic                      id_re, id_we;
  logic [IW-1:0]             id_ridx, id_widx;
  logic [lnss_pkg::ID_W-1:0] id_wdata, id_rdata;

  // Search outcome in this cycle
  logic          hit, miss;
  logic [CW-1:0] hit_idx, cnt_cur;

  function automatic logic [AW-1:0] ent_addr(logic [LW-1:0] l, logic [IW-1:0] i);
    return AW'(l) * ROW_A + AW'(i);
  endfunction

  lnss_id_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_id_ram (
    .clk_i   (clk_i),
    .we_i    (id_we),
    .waddr_i (ent_addr(layer_q, id_widx)),
    .wdata_i (id_wdata),
    .re_i    (id_re),
    .raddr_i (ent_addr(layer_q, id_ridx)),
    .rdata_o (id_rdata)
  );

  lnss_cnt_store #(
    .LAYERS (MAX_LAYERS),
    .LW     (LW),
    .CW     (CW)
  ) u_cnt_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cnt_we),
    .waddr_i (layer_q),
    .wdata_i (cnt_wdata),
    .re_i    (cnt_re),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  assign cnt_cur = (state_q == S_CNT) ? cnt_rdata : cnt_q;

  // Sequencer: fetch count, scan entries, shift on removal, read entry, report
  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    layer_d   = layer_q;
    oob_d     = oob_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    done_d    = 1'b0;
    rsp_d     = rsp_q;
    cnt_re    = 1'b0;
    cnt_raddr = LW'(req_i.layer_select);
    cnt_we    = 1'b0;
    cnt_wdata = cnt_q;
    id_re     = 1'b0;
    id_ridx   = '0;
    id_we     = 1'b0;
    id_widx   = '0;
    id_wdata  = req_q.neighbor_id;
    hit       = 1'b0;
    miss      = 1'b0;
    hit_idx   = idx_q;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          req_d   = req_i;
          layer_d = LW'(req_i.layer_select);
          oob_d   = (req_i.layer_select > top_q) ||
                    (7'(req_i.layer_select) >= 7'(MAX_LAYERS));
          cnt_re  = !oob_d;
          state_d = S_CNT;
        end
      end

      S_CNT: begin
        rsp_d = '0;
        if (oob_q) begin
          rsp_d.status = lnss_pkg::ST_OOB;
          done_d       = 1'b1;
          state_d      = S_IDLE;
        end else begin
          cnt_d            = cnt_rdata;
          rsp_d.list_count = lnss_pkg::COUNT_W'(cnt_rdata);
          case (req_q.op) inside
            lnss_pkg::OP_ADD, lnss_pkg::OP_REMOVE, lnss_pkg::OP_HAS: begin
              if (cnt_rdata == '0) begin
                miss = 1'b1;
              end else begin
                id_re   = 1'b1;
                id_ridx = '0;
                idx_d   = '0;
                state_d = S_SCAN;
              end
            end
            lnss_pkg::OP_CLEAR: begin
              cnt_we           = 1'b1;
              cnt_wdata        = '0;
              rsp_d.list_count = '0;
              done_d           = 1'b1;
              state_d          = S_IDLE;
            end
            lnss_pkg::OP_READ: begin
              if (CMPW'(req_q.read_index) < CMPW'(cnt_rdata)) begin
                id_re   = 1'b1;
                id_ridx = IW'(req_q.read_index);
                state_d = S_RDWAIT;
              end else begin
                rsp_d.status = lnss_pkg::ST_PAST_END;
                done_d       = 1'b1;
                state_d      = S_IDLE;
              end
            end
            default: begin
              done_d  = 1'b1;
              state_d = S_IDLE;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (id_rdata == req_q.neighbor_id) begin
          hit = 1'b1;
        end else if (idx_q + ONE_C < cnt_q) begin
          id_re   = 1'b1;
          id_ridx = idx_q[IW-1:0] + IW'(1);
          idx_d   = idx_q + ONE_C;
        end else begin
          miss = 1'b1;
        end
      end

      S_SHIFT: begin
        // Move the entry read last cycle one place down
        id_we    = 1'b1;
        id_widx  = idx_q[IW-1:0] - IW'(1);
        id_wdata = id_rdata;
        if (idx_q + ONE_C < cnt_q) begin
          id_re   = 1'b1;
          id_ridx = idx_q[IW-1:0] + IW'(1);
          idx_d   = idx_q + ONE_C;
        end else begin
          cnt_we           = 1'b1;
          cnt_wdata        = cnt_q - ONE_C;
          rsp_d.list_count = lnss_pkg::COUNT_W'(cnt_q - ONE_C);
          done_d           = 1'b1;
          state_d          = S_IDLE;
        end
      end

      S_RDWAIT: begin
        rsp_d.entry_value = id_rdata;
        done_d            = 1'b1;
        state_d           = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Id found at hit_idx
    if (hit) begin
      rsp_d.position = lnss_pkg::POS_W'(hit_idx);
      case (req_q.op)
        lnss_pkg::OP_REMOVE: begin
          rsp_d.succeeded = 1'b1;
          if (hit_idx + ONE_C < cnt_cur) begin
            id_re   = 1'b1;
            id_ridx = hit_idx[IW-1:0] + IW'(1);
            idx_d   = hit_idx + ONE_C;
            state_d = S_SHIFT;
          end else begin
            cnt_we           = 1'b1;
            cnt_wdata        = cnt_cur - ONE_C;
            rsp_d.list_count = lnss_pkg::COUNT_W'(cnt_cur - ONE_C);
            done_d           = 1'b1;
            state_d          = S_IDLE;
          end
        end
        lnss_pkg::OP_HAS: begin
          rsp_d.succeeded = 1'b1;
          done_d          = 1'b1;
          state_d         = S_IDLE;
        end
        default: begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      endcase
    end

    // Id absent: append on add (full status if no room), else report not found
    if (miss) begin
      rsp_d.position = '0;
      done_d         = 1'b1;
      state_d        = S_IDLE;
      if (req_q.op == lnss_pkg::OP_ADD) begin
        if (cnt_cur >= FULL_C) begin
          rsp_d.status = lnss_pkg::ST_FULL;
        end else begin
          id_we            = 1'b1;
          id_widx          = cnt_cur[IW-1:0];
          id_wdata         = req_q.neighbor_id;
          cnt_we           = 1'b1;
          cnt_wdata        = cnt_cur + ONE_C;
          rsp_d.succeeded  = 1'b1;
          rsp_d.position   = lnss_pkg::POS_W'(cnt_cur);
          rsp_d.list_count = lnss_pkg::COUNT_W'(cnt_cur + ONE_C);
        end
      end
    end
  end

  // Hold state, request, configuration and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      req_q   <= '0;
      layer_q <= '0;
      oob_q   <= 1'b0;
      cnt_q   <= '0;
      idx_q   <= '0;
      done_q  <= 1'b0;
      rsp_q   <= '0;
      top_q   <= '0;
    end else begin
      state_q <= state_d;
      req_q   <= req_d;
      layer_q <= layer_d;
      oob_q   <= oob_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      done_q  <= done_d;
      rsp_q   <= rsp_d;
      if (cfg_we_i) begin
        top_q <= cfg_wdata_i;
      end
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// ===== rtl/core/lnss_checker.sv =====
module lnss_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start_i,
  input logic           busy_o,
  input logic           done_o,
  input lnss_pkg::rsp_t rsp_o
);

  // A result strobe frees the block in the same cycle
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while busy");

  // A transferred request makes the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("request transfer did not start work");

  // Busy ends only with a result
  a_fall_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> done_o)
    else $error("busy dropped without a result");

  // One result per request: strobes never come back to back
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobes back to back");

  // Out-of-bounds layer reports nothing else
  a_oob_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status == lnss_pkg::ST_OOB) |->
      (!rsp_o.succeeded && rsp_o.position == '0 &&
       rsp_o.entry_value == '0 && rsp_o.list_count == '0))
    else $error("out-of-bounds result carries data");

endmodule

bind layered_neighbor_set_store_unit lnss_checker u_lnss_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .done_o  (done_o),
  .rsp_o   (rsp_o)
);
